[rtl/core/scm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scm_pkg
// Shared widths, limits and types for the spatial correlation metric unit.
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int MAX_LEN = 65536;
  localparam int VAL_W   = 16;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int PRD_W   = 2 * VAL_W;
  localparam int SQE_W   = 2 * VAL_W - 1;
  localparam int DOT_W   = 48;
  localparam int SQ_W    = 47;
  localparam int MAG_W   = 47;
  localparam int MUL_W   = 2 * SQ_W;
  localparam int DVD_W   = 128;
  localparam int REM_W   = MUL_W + 1;
  localparam int QUO_W   = 48;
  localparam int RAD_W   = 36;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int SREM_W  = ROOT_W + 4;
  localparam int MET_W   = 32;
  localparam int STEP_W  = 8;
  localparam int COS_SHIFT   = 34;
  localparam int MORAN_STEPS = QUO_W;
  localparam int COS_STEPS   = DVD_W;

  localparam logic [0:0] MODE_MORAN  = 1'b0;
  localparam logic [0:0] MODE_COSINE = 1'b1;

  typedef struct packed {
    logic                    f_last;
    logic signed [VAL_W-1:0] factor;
    logic signed [VAL_W-1:0] lag;
  } beat_t;

  typedef struct packed {
    logic                    valid;
    logic signed [DOT_W-1:0] dot;
    logic [SQ_W-1:0]         fsq;
    logic [SQ_W-1:0]         lsq;
    logic [CNT_W-1:0]        count;
  } close_t;

  typedef enum logic [2:0] {
    FIN_IDLE,
    FIN_MUL_NORM,
    FIN_MUL_DOT,
    FIN_DIV,
    FIN_SQRT,
    FIN_DONE
  } fin_state_t;

endpackage
`default_nettype wire

[rtl/core/spatial_correlation_metric_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spatial_correlation_metric_unit
// Streams Q4.12 element pairs, accumulates their dot product and sums of
// squares, and on the closing element emits Moran's I or cosine similarity
// in Q15.16.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Beat
// input     in         start high, busy low   factor_value, lag_value, last
// config    in         cfg_valid & cfg_ready  cfg_data (metric_mode)
// result    out        result_valid strobe    metric_value, undefined,
//                                              element_count
//
// Element beats are taken one per cycle while the finishing sequencer is idle,
// and multiplied and accumulated at that rate. When a vector closes, the
// finishing sequencer owns the block: Moran's I takes one quotient bit a
// cycle, and cosine similarity runs two 47-step shift-add multiplications, a
// 128-step division and an 18-step square root. The two-entry input queue
// keeps taking beats until it fills. Reset is synchronous and clears the
// queue, accumulators, sequencer and the mode register (Moran's I).
// The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module spatial_correlation_metric_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [scm_pkg::VAL_W-1:0]    factor_value,
  input  wire logic signed [scm_pkg::VAL_W-1:0]    lag_value,
  input  wire logic                                last,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic                                cfg_data,
  output logic                                     result_valid,
  output logic signed [scm_pkg::MET_W-1:0]         metric_value,
  output logic                                     undefined,
  output logic [scm_pkg::CNT_W-1:0]                element_count
);
  import scm_pkg::*;

  logic   metric_mode;
  beat_t  in_beat;
  beat_t  pop_beat;
  logic   pop_req;
  logic   pop;
  logic   fin_busy;
  close_t close;

  // The mode register can always take a write; the user is to change it only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= MODE_MORAN;
    end else if (cfg_valid && cfg_ready) begin
      metric_mode <= cfg_data;
    end
  end

  assign in_beat.f_last = last;
  assign in_beat.factor = factor_value;
  assign in_beat.lag    = lag_value;

  scm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (start),
    .push_beat (in_beat),
    .full      (busy),
    .pop_req   (pop_req),
    .pop       (pop),
    .pop_beat  (pop_beat)
  );

  scm_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .fin_busy (fin_busy),
    .pop_req  (pop_req),
    .pop      (pop),
    .pop_beat (pop_beat),
    .close    (close)
  );

  scm_finish u_finish (
    .clk           (clk),
    .rst           (rst),
    .mode          (metric_mode),
    .close         (close),
    .fin_busy      (fin_busy),
    .result_valid  (result_valid),
    .metric_value  (metric_value),
    .undefined     (undefined),
    .element_count (element_count)
  );

endmodule
`default_nettype wire

[rtl/core/scm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scm_front
// Two-entry input queue that takes element beats and hands them to the
// accumulator when it asks for one.
// ----------------------------------------------------------------------------
module scm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire scm_pkg::beat_t push_beat,
  output logic               full,
  input  wire logic          pop_req,
  output logic               pop,
  output scm_pkg::beat_t     pop_beat
);
  import scm_pkg::*;

  beat_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push_ok;

  assign full     = (fill == 2'd2);
  assign push_ok  = push && !full;
  assign pop      = pop_req && (fill != 2'd0);
  assign pop_beat = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_ok && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push_ok) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_beat;
    end
  end

endmodule
`default_nettype wire

[rtl/core/scm_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scm_mac
// Product stage and accumulators. Closes a vector on the marked element or
// at the length limit and passes the totals to the finishing unit.
// ----------------------------------------------------------------------------
module scm_mac (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fin_busy,
  output logic                pop_req,
  input  wire logic           pop,
  input  wire scm_pkg::beat_t pop_beat,
  output scm_pkg::close_t     close
);
  import scm_pkg::*;

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_after;
  logic                    is_close;
  logic signed [PRD_W-1:0] p_fl;
  logic signed [PRD_W-1:0] p_ff;
  logic signed [PRD_W-1:0] p_ll;

  logic                    s1_valid;
  logic                    s1_close;
  logic [CNT_W-1:0]        s1_count;
  logic signed [PRD_W-1:0] s1_fl;
  logic [SQE_W-1:0]        s1_ff;
  logic [SQE_W-1:0]        s1_ll;

  logic signed [DOT_W-1:0] dot;
  logic [SQ_W-1:0]         fsq;
  logic [SQ_W-1:0]         lsq;
  logic signed [DOT_W-1:0] dot_next;
  logic [SQ_W-1:0]         fsq_next;
  logic [SQ_W-1:0]         lsq_next;

  // A closing element holds off further pops until the finisher has it.
  assign pop_req     = !fin_busy && !(s1_valid && s1_close);
  assign count_after = count + CNT_W'(1);
  assign is_close    = pop_beat.f_last || (count_after == CNT_W'(MAX_LEN));

  assign p_fl = pop_beat.factor * pop_beat.lag;
  assign p_ff = pop_beat.factor * pop_beat.factor;
  assign p_ll = pop_beat.lag * pop_beat.lag;

  assign dot_next = dot + DOT_W'(s1_fl);
  assign fsq_next = fsq + SQ_W'(s1_ff);
  assign lsq_next = lsq + SQ_W'(s1_ll);

  assign close.valid = s1_valid && s1_close;
  assign close.dot   = dot_next;
  assign close.fsq   = fsq_next;
  assign close.lsq   = lsq_next;
  assign close.count = s1_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      s1_valid <= 1'b0;
      s1_close <= 1'b0;
      dot      <= '0;
      fsq      <= '0;
      lsq      <= '0;
    end else begin
      s1_valid <= pop;
      if (pop) begin
        s1_close <= is_close;
        count    <= is_close ? '0 : count_after;
      end
      if (s1_valid) begin
        if (s1_close) begin
          dot <= '0;
          fsq <= '0;
          lsq <= '0;
        end else begin
          dot <= dot_next;
          fsq <= fsq_next;
          lsq <= lsq_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_count <= count_after;
      s1_fl    <= p_fl;
      s1_ff    <= p_ff[SQE_W-1:0];
      s1_ll    <= p_ll[SQE_W-1:0];
    end
  end

endmodule
`default_nettype wire

[rtl/core/scm_finish.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scm_finish
// Sequencer for the end of a vector: shift-add multiplier, restoring
// divider and digit-by-digit square root, then rounding and saturation.
// ----------------------------------------------------------------------------
module scm_finish (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            mode,
  input  wire scm_pkg::close_t close,
  output logic                 fin_busy,
  output logic                 result_valid,
  output logic signed [scm_pkg::MET_W-1:0] metric_value,
  output logic                 undefined,
  output logic [scm_pkg::CNT_W-1:0] element_count
);
  import scm_pkg::*;

  fin_state_t state;
  fin_state_t state_next;

  logic              mode_r;
  logic              neg;
  logic              undef_r;
  logic [CNT_W-1:0]  count_r;
  logic [MAG_W-1:0]  mag;
  logic [SQ_W-1:0]   mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [MUL_W-1:0]  mul_acc;
  logic [MUL_W-1:0]  divisor;
  logic [DVD_W-1:0]  dividend;
  logic [MUL_W-1:0]  rem;
  logic [QUO_W-1:0]  quot;
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W-1:0] root;
  logic [SREM_W-1:0] srem;
  logic [STEP_W-1:0] step;

  logic [MAG_W-1:0]  close_mag;
  logic [QUO_W-1:0]  moran_num;
  logic [MUL_W-1:0]  mul_sum;
  logic [REM_W-1:0]  rem_sh;
  logic              div_ge;
  logic [SREM_W-1:0] srem_sh;
  logic [SREM_W-1:0] trial;
  logic              sqrt_ge;
  logic [ROOT_W-1:0] cos_q;
  logic [QUO_W-1:0]  res_mag;
  logic [MET_W-1:0]  res_val;
  logic              last_step;

  localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'({1'b0, {(MET_W-1){1'b1}}});
  localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'({1'b1, {(MET_W-1){1'b0}}});

  assign close_mag = close.dot[DOT_W-1] ? MAG_W'(-close.dot) : MAG_W'(close.dot);
  assign moran_num = QUO_W'(close_mag) + (QUO_W'(close.count) << 7);
  assign mul_sum   = mul_acc + (mul_a[0] ? mul_b : '0);
  assign rem_sh    = {rem, dividend[DVD_W-1]};
  assign div_ge    = rem_sh >= REM_W'(divisor);
  assign srem_sh   = {srem[SREM_W-3:0], rad[RAD_W-1:RAD_W-2]};
  assign trial     = SREM_W'({root, 2'b01});
  assign sqrt_ge   = srem_sh >= trial;
  assign last_step = (step == '0);
  assign cos_q     = (root + ROOT_W'(1)) >> 1;
  assign res_mag   = undef_r ? '0 : ((mode_r == MODE_COSINE) ? QUO_W'(cos_q) : quot);

  always_comb begin
    if (!neg) begin
      res_val = (res_mag > POS_LIMIT) ? MET_W'(POS_LIMIT) : MET_W'(res_mag);
    end else begin
      res_val = (res_mag > NEG_LIMIT) ? MET_W'(NEG_LIMIT) : MET_W'(-res_mag);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      FIN_IDLE: begin
        if (close.valid) begin
          if (mode == MODE_MORAN) begin
            state_next = FIN_DIV;
          end else if (close.fsq == '0 || close.lsq == '0) begin
            state_next = FIN_DONE;
          end else begin
            state_next = FIN_MUL_NORM;
          end
        end
      end
      FIN_MUL_NORM: begin
        if (last_step) state_next = FIN_MUL_DOT;
      end
      FIN_MUL_DOT: begin
        if (last_step) state_next = FIN_DIV;
      end
      FIN_DIV: begin
        if (last_step) state_next = (mode_r == MODE_COSINE) ? FIN_SQRT : FIN_DONE;
      end
      FIN_SQRT: begin
        if (last_step) state_next = FIN_DONE;
      end
      FIN_DONE: begin
        state_next = FIN_IDLE;
      end
      default: begin
        state_next = FIN_IDLE;
      end
    endcase
  end

  always_comb begin
    fin_busy = (state != FIN_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= FIN_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == FIN_DONE);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      FIN_IDLE: begin
        if (close.valid) begin
          mode_r  <= mode;
          neg     <= close.dot[DOT_W-1];
          count_r <= close.count;
          mag     <= close_mag;
          undef_r <= (mode == MODE_COSINE) && (close.fsq == '0 || close.lsq == '0);
          rem     <= '0;
          quot    <= '0;
          if (mode == MODE_MORAN) begin
            divisor  <= MUL_W'(close.count) << 8;
            dividend <= {moran_num, {(DVD_W-QUO_W){1'b0}}};
            step     <= STEP_W'(MORAN_STEPS - 1);
          end else begin
            mul_a   <= close.fsq;
            mul_b   <= MUL_W'(close.lsq);
            mul_acc <= '0;
            step    <= STEP_W'(SQ_W - 1);
          end
        end
      end
      FIN_MUL_NORM: begin
        mul_a <= mul_a >> 1;
        mul_b <= mul_b << 1;
        step  <= step - STEP_W'(1);
        if (last_step) begin
          divisor <= mul_sum;
          mul_a   <= mag;
          mul_b   <= MUL_W'(mag);
          mul_acc <= '0;
          step    <= STEP_W'(SQ_W - 1);
        end else begin
          mul_acc <= mul_sum;
        end
      end
      FIN_MUL_DOT: begin
        mul_a   <= mul_a >> 1;
        mul_b   <= mul_b << 1;
        mul_acc <= mul_sum;
        step    <= step - STEP_W'(1);
        if (last_step) begin
          dividend <= {mul_sum, {COS_SHIFT{1'b0}}};
          step     <= STEP_W'(COS_STEPS - 1);
        end
      end
      FIN_DIV: begin
        dividend <= dividend << 1;
        rem      <= div_ge ? MUL_W'(rem_sh - REM_W'(divisor)) : rem_sh[MUL_W-1:0];
        quot     <= {quot[QUO_W-2:0], div_ge};
        step     <= step - STEP_W'(1);
        if (last_step) begin
          rad  <= {quot[RAD_W-2:0], div_ge};
          root <= '0;
          srem <= '0;
          step <= STEP_W'(ROOT_W - 1);
        end
      end
      FIN_SQRT: begin
        rad  <= rad << 2;
        srem <= sqrt_ge ? (srem_sh - trial) : srem_sh;
        root <= {root[ROOT_W-2:0], sqrt_ge};
        step <= step - STEP_W'(1);
      end
      FIN_DONE: begin
        metric_value  <= res_val;
        undefined     <= undef_r;
        element_count <= count_r;
      end
      default: begin
        step <= '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_close_when_idle: assert property (@(posedge clk) disable iff (rst)
    close.valid |-> state == FIN_IDLE)
    else $error("vector closed while the finisher was busy");
  a_strobe_after_done: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == FIN_DONE))
    else $error("result strobe without a finished computation");
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && undefined) |-> metric_value == '0)
    else $error("undefined result carries a nonzero metric");
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");
`endif

endmodule
`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Spatial correlation metric unit testbench
// Streams element pairs into the unit under both metric modes, predicts each
// closing result with an exact integer model of Moran's I and cosine
// similarity, and compares every strobed result field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scm_pkg::*;

  // One expected metric result.
  typedef struct {
    logic signed [MET_W-1:0] metric;
    logic                    undef;
    logic [CNT_W-1:0]        count;
  } metric_result_t;

  // Scoreboard: keeps its own copy of the accumulators and the mode, turns
  // every accepted element beat into the metric it closes, if any, and checks
  // strobed results against the oldest waiting prediction.
  class metric_scoreboard;
    logic [0:0]               mode;
    logic signed [DOT_W-1:0]  dot_acc;
    logic [SQ_W-1:0]          fsq_acc;
    logic [SQ_W-1:0]          lsq_acc;
    int unsigned              pairs;
    metric_result_t           pending[$];
    int unsigned              mismatches;

    function void clear_sums();
      dot_acc = '0;
      fsq_acc = '0;
      lsq_acc = '0;
      pairs = 0;
    endfunction

    // Largest q in [0, 65536] with (2q-1)^2 * fsq * lsq <= dot^2 * 2^34,
    // which is 65536 * |dot| / sqrt(fsq * lsq) rounded half away from zero.
    function longint cosine_mag(logic [MAG_W-1:0] mag);
      logic [255:0] norm_prod;
      logic [255:0] lhs;
      logic [255:0] rhs;
      longint lo;
      longint hi;
      longint mid;
      lo = 0;
      hi = 65536;
      norm_prod = 256'(fsq_acc) * 256'(lsq_acc);
      rhs = (256'(mag) * 256'(mag)) << COS_SHIFT;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = 256'((2 * mid - 1) * (2 * mid - 1)) * norm_prod;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function void note_pair(logic signed [VAL_W-1:0] f, logic signed [VAL_W-1:0] l,
                            logic is_last);
      metric_result_t r;
      logic [MAG_W-1:0] mag;
      longint m;
      longint d;
      dot_acc = dot_acc + DOT_W'(longint'(f) * longint'(l));
      fsq_acc = fsq_acc + SQ_W'(longint'(f) * longint'(f));
      lsq_acc = lsq_acc + SQ_W'(longint'(l) * longint'(l));
      pairs++;
      if (!is_last && pairs < MAX_LEN) return;
      mag = dot_acc < 0 ? MAG_W'(-dot_acc) : MAG_W'(dot_acc);
      r.undef = 1'b0;
      m = 0;
      if (mode == MODE_MORAN) begin
        d = longint'(pairs) * 256;
        m = (longint'(mag) + d / 2) / d;
      end else if (fsq_acc == 0 || lsq_acc == 0) begin
        r.undef = 1'b1;
      end else begin
        m = cosine_mag(mag);
      end
      if (dot_acc < 0) m = -m;
      if (m > 64'sd2147483647) m = 64'sd2147483647;
      if (m < -64'sd2147483648) m = -64'sd2147483648;
      r.metric = MET_W'(m);
      r.count = CNT_W'(pairs);
      pending.push_back(r);
      clear_sums();
    endfunction

    function void check_result(logic signed [MET_W-1:0] metric, logic undef,
                               logic [CNT_W-1:0] count);
      metric_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: metric=%0d undefined=%0b count=%0d",
                   metric, undef, count);
        return;
      end
      e = pending.pop_front();
      if (metric !== e.metric || undef !== e.undef || count !== e.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch (metric/undefined/count): expected %0d/%0b/%0d, got %0d/%0b/%0d",
                   e.metric, e.undef, e.count, metric, undef, count);
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [VAL_W-1:0] factor_value = '0;
  logic signed [VAL_W-1:0] lag_value = '0;
  logic last = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic result_valid;
  logic signed [MET_W-1:0] metric_value;
  logic undefined;
  logic [CNT_W-1:0] element_count;

  metric_scoreboard board;
  int unsigned idle_cycles;

  always #6 clk = ~clk;

  spatial_correlation_metric_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .factor_value(factor_value), .lag_value(lag_value), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .metric_value(metric_value),
    .undefined(undefined), .element_count(element_count)
  );

  // Results cannot be stalled, so every strobe is checked at the edge that
  // ends it. Element beats are noted at the edge that accepts them. The
  // watchdog counts edges at which nothing was accepted and no result came.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid)
        board.check_result(metric_value, undefined, element_count);
      if (start && !busy)
        board.note_pair(factor_value, lag_value, last);
      if (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Offer one element beat and hold it until the unit takes it. start stays
  // high across back-to-back beats; the caller lowers it for gaps.
  task automatic send_pair(logic signed [VAL_W-1:0] f, logic signed [VAL_W-1:0] l,
                           logic is_last);
    start <= 1'b1;
    factor_value <= f;
    lag_value <= l;
    last <= is_last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Waits until every predicted result has come, then lets the finishing
  // sequencer drain in case a beat left it working on nothing visible.
  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Mode writes happen only while the unit is idle.
  task automatic write_mode(logic [0:0] m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.mode = m;
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return VAL_W'($urandom_range(0, 15)) - 16'sd8;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // One vector of random length with random content; the sender works in
  // bursts and sometimes gaps between beats.
  task automatic send_vector(int len, int kind);
    logic signed [VAL_W-1:0] f;
    logic signed [VAL_W-1:0] l;
    int burst;
    burst = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      f = rand_value();
      l = rand_value();
      if (kind == 1) l = f;
      if (kind == 2) l = -f;
      if (kind == 3) f = '0;
      if (kind == 4) l = '0;
      send_pair(f, l, i == len - 1);
      if (--burst == 0) begin
        burst = $urandom_range(1, 8);
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
      end
    end
  endtask

  int sent;

  initial begin
    board = new();
    board.mode = MODE_MORAN;
    board.clear_sums();
    board.mismatches = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: field extremes, a single-element vector, and both modes.
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    send_pair(16'sh0001, 16'shFFFF, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b1);
    write_mode(MODE_COSINE);
    send_pair(16'sh0000, 16'sh1234, 1'b1);   // zero factor norm
    send_pair(16'sh4321, 16'sh0000, 1'b1);   // zero lag norm
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);   // perfect alignment
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);   // opposite directions
    send_pair(16'sh1000, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh1000, 1'b1);   // orthogonal
    send_pair(16'sh0003, 16'sh0001, 1'b0);
    send_pair(16'sh0001, 16'sh0003, 1'b1);
    write_mode(MODE_MORAN);
    send_pair(16'sh0001, 16'sh0001, 1'b0);
    send_pair(16'sh0001, 16'sh0001, 1'b1);   // rounds to zero after /count
    send_pair(16'sh0010, 16'sh0008, 1'b1);   // exact half rounds away

    // Random part: vectors of mostly short length, mode changed between phases.
    sent = 17;
    while (sent < 1400) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      send_vector(len, $urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 4));
      sent += len;
      if ($urandom_range(0, 39) == 0) write_mode(1'($urandom_range(0, 1)));
      else if ($urandom_range(0, 29) == 0) drain();
    end

    drain();
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

[files.f]
rtl/core/scm_pkg.sv
rtl/core/scm_front.sv
rtl/core/scm_mac.sv
rtl/core/scm_finish.sv
rtl/core/spatial_correlation_metric_unit.sv
verif/tb.sv
